>>> rtl/pru_pkg.sv
// pru_pkg: shared widths, limits, codes and the control struct of the pixel
// replication upscaler. Used by pru_ctrl, pru_out and pixel_replication_upscaler.
// No dependencies.
package pru_pkg;

    // Line store limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_FACTOR = 100;

    // Field and register widths
    localparam int COLOR_W = 8;
    localparam int PIX_W   = 3 * COLOR_W;
    localparam int W_W     = 11;
    localparam int H_W     = 16;
    localparam int F_W     = 7;
    localparam int PAD_W   = 2;
    localparam int ADDR_W  = $clog2(MAX_WIDTH);
    localparam int FILL_W  = $clog2(MAX_WIDTH + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Commands
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_PULL = 1'b1;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_WIDTH  = 2'd0,
        REG_IN_HEIGHT = 2'd1,
        REG_FACTOR    = 2'd2
    } reg_idx_t;

    // What one accepted item produces, passed from control to output stage
    typedef struct packed {
        logic accepted;
        logic out_valid;
        logic is_padding;
        logic pixel;        // take colour from line store read data
        logic end_of_row;
        logic end_of_frame;
    } meta_t;

endpackage

>>> rtl/pru_ram.sv
// pru_ram: generic single-write, single-read synchronous RAM with registered
// read data and read enable. No dependencies.
module pru_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/pru_ctrl.sv
// pru_ctrl: configuration registers, stream counters and line store addressing.
// Depends on pru_pkg.
module pru_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [pru_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pru_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_fire,
    input  logic                           command,
    input  logic [pru_pkg::PIX_W-1:0]      pix,
    output logic                           ram_we,
    output logic [pru_pkg::ADDR_W-1:0]     ram_waddr,
    output logic [pru_pkg::PIX_W-1:0]      ram_wdata,
    output logic                           ram_re,
    output logic [pru_pkg::ADDR_W-1:0]     ram_raddr,
    output pru_pkg::meta_t                 meta
);

    logic [pru_pkg::W_W-1:0]    w_eff_reg, w_eff_next;
    logic [pru_pkg::H_W-1:0]    h_eff_reg, h_eff_next;
    logic [pru_pkg::F_W-1:0]    f_eff_reg, f_eff_next;

    logic [pru_pkg::FILL_W-1:0] fill_reg, fill_next;
    logic [pru_pkg::ADDR_W-1:0] col_reg, col_next;
    logic [pru_pkg::F_W-1:0]    rep_reg, rep_next;
    logic [pru_pkg::F_W-1:0]    copy_reg, copy_next;
    logic [pru_pkg::PAD_W-1:0]  pad_reg, pad_next;
    logic [pru_pkg::H_W-1:0]    row_reg, row_next;
    logic                       phase_reg, phase_next;

    logic [pru_pkg::W_W-1:0]    cfg_w;
    logic [pru_pkg::H_W-1:0]    cfg_h;
    logic [pru_pkg::F_W-1:0]    cfg_f;
    logic [2*pru_pkg::PAD_W-1:0] pad_prod;
    logic [pru_pkg::PAD_W-1:0]  npad;
    logic [pru_pkg::FILL_W:0]   col_ext;
    logic [pru_pkg::FILL_W:0]   col_inc;
    logic [pru_pkg::F_W:0]      rep_inc;
    logic [pru_pkg::F_W:0]      copy_inc;
    logic [pru_pkg::PAD_W:0]    pad_inc;
    logic [pru_pkg::H_W:0]      row_inc;
    logic                       row_done;
    logic                       restart;

    // Padding bytes = (w * f) mod 4: only the two low bits of each matter
    assign pad_prod = w_eff_reg[pru_pkg::PAD_W-1:0] * f_eff_reg[pru_pkg::PAD_W-1:0];
    assign npad     = pad_prod[pru_pkg::PAD_W-1:0];

    assign col_ext  = (pru_pkg::FILL_W+1)'(col_reg);
    assign col_inc  = col_ext + 1'b1;
    assign rep_inc  = {1'b0, rep_reg} + 1'b1;
    assign copy_inc = {1'b0, copy_reg} + 1'b1;
    assign pad_inc  = {1'b0, pad_reg} + 1'b1;
    assign row_inc  = {1'b0, row_reg} + 1'b1;

    // Register writes, clamped to the working range
    assign cfg_w = cfg_data[pru_pkg::W_W-1:0];
    assign cfg_h = cfg_data[pru_pkg::H_W-1:0];
    assign cfg_f = cfg_data[pru_pkg::F_W-1:0];

    always_comb
    begin
        w_eff_next = w_eff_reg;
        h_eff_next = h_eff_reg;
        f_eff_next = f_eff_reg;
        restart    = 1'b0;
        if (cfg_valid)
        begin
            case (cfg_index)
                pru_pkg::REG_IN_WIDTH:
                begin
                    restart = 1'b1;
                    if (cfg_w == '0)
                        w_eff_next = pru_pkg::W_W'(1);
                    else if (cfg_w > pru_pkg::W_W'(pru_pkg::MAX_WIDTH))
                        w_eff_next = pru_pkg::W_W'(pru_pkg::MAX_WIDTH);
                    else
                        w_eff_next = cfg_w;
                end
                pru_pkg::REG_IN_HEIGHT:
                begin
                    restart    = 1'b1;
                    h_eff_next = (cfg_h == '0) ? pru_pkg::H_W'(1) : cfg_h;
                end
                pru_pkg::REG_FACTOR:
                begin
                    restart = 1'b1;
                    if (cfg_f == '0)
                        f_eff_next = pru_pkg::F_W'(1);
                    else if (cfg_f > pru_pkg::F_W'(pru_pkg::MAX_FACTOR))
                        f_eff_next = pru_pkg::F_W'(pru_pkg::MAX_FACTOR);
                    else
                        f_eff_next = cfg_f;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    // Per-item decisions and counter updates
    always_comb
    begin
        fill_next  = fill_reg;
        col_next   = col_reg;
        rep_next   = rep_reg;
        copy_next  = copy_reg;
        pad_next   = pad_reg;
        row_next   = row_reg;
        phase_next = phase_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        meta       = '0;
        row_done   = 1'b0;

        if (in_fire)
        begin
            if (command == pru_pkg::CMD_PUSH)
            begin
                if (fill_reg < pru_pkg::FILL_W'(w_eff_reg))
                begin
                    ram_we        = 1'b1;
                    fill_next     = fill_reg + 1'b1;
                    meta.accepted = 1'b1;
                end
            end
            else if (phase_reg)
            begin
                meta.out_valid  = 1'b1;
                meta.is_padding = 1'b1;
                pad_next        = pad_inc[pru_pkg::PAD_W-1:0];
                if (pad_inc >= (pru_pkg::PAD_W+1)'(npad))
                begin
                    meta.end_of_row = 1'b1;
                    row_done        = 1'b1;
                end
            end
            else if ((col_ext < (pru_pkg::FILL_W+1)'(fill_reg)) &&
                     (col_ext < (pru_pkg::FILL_W+1)'(w_eff_reg)))
            begin
                ram_re         = 1'b1;
                meta.out_valid = 1'b1;
                meta.pixel     = 1'b1;
                rep_next       = rep_inc[pru_pkg::F_W-1:0];
                if (rep_inc >= (pru_pkg::F_W+1)'(f_eff_reg))
                begin
                    rep_next = '0;
                    // col wraps harmlessly at full width: unused in padding
                    col_next = col_inc[pru_pkg::ADDR_W-1:0];
                    if (col_inc >= (pru_pkg::FILL_W+1)'(w_eff_reg))
                    begin
                        if (npad != '0)
                        begin
                            phase_next = 1'b1;
                            pad_next   = '0;
                        end
                        else
                        begin
                            meta.end_of_row = 1'b1;
                            row_done        = 1'b1;
                        end
                    end
                end
            end
        end

        // Close an output row; last copy frees the line store
        if (row_done)
        begin
            phase_next = 1'b0;
            pad_next   = '0;
            col_next   = '0;
            rep_next   = '0;
            if (copy_inc >= (pru_pkg::F_W+1)'(f_eff_reg))
            begin
                copy_next = '0;
                fill_next = '0;
                if (row_inc >= (pru_pkg::H_W+1)'(h_eff_reg))
                begin
                    row_next          = '0;
                    meta.end_of_frame = 1'b1;
                end
                else
                begin
                    row_next = row_inc[pru_pkg::H_W-1:0];
                end
            end
            else
            begin
                copy_next = copy_inc[pru_pkg::F_W-1:0];
            end
        end

        if (restart)
        begin
            fill_next  = '0;
            col_next   = '0;
            rep_next   = '0;
            copy_next  = '0;
            pad_next   = '0;
            row_next   = '0;
            phase_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_eff_reg <= pru_pkg::W_W'(1);
            h_eff_reg <= pru_pkg::H_W'(1);
            f_eff_reg <= pru_pkg::F_W'(1);
            fill_reg  <= '0;
            col_reg   <= '0;
            rep_reg   <= '0;
            copy_reg  <= '0;
            pad_reg   <= '0;
            row_reg   <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            w_eff_reg <= w_eff_next;
            h_eff_reg <= h_eff_next;
            f_eff_reg <= f_eff_next;
            fill_reg  <= fill_next;
            col_reg   <= col_next;
            rep_reg   <= rep_next;
            copy_reg  <= copy_next;
            pad_reg   <= pad_next;
            row_reg   <= row_next;
            phase_reg <= phase_next;
        end
    end

    assign ram_waddr = fill_reg[pru_pkg::ADDR_W-1:0];
    assign ram_wdata = pix;
    assign ram_raddr = col_reg;

`ifndef SYNTHESIS
    a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("line store written and read by one item");

    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= pru_pkg::FILL_W'(w_eff_reg))
        else $error("fill count beyond row width");

    a_read_stored: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (col_ext < (pru_pkg::FILL_W+1)'(fill_reg)))
        else $error("read of a pixel not yet stored");

    a_pad_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (pad_reg < npad))
        else $error("padding count overran");

    a_frame_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
        meta.end_of_frame |-> (meta.end_of_row && row_done))
        else $error("end of frame without end of row");
`endif

endmodule

>>> rtl/pru_out.sv
// pru_out: result stage (waits on line store read data) and output register.
// Depends on pru_pkg.
module pru_out (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_fire,
    input  pru_pkg::meta_t               meta,
    input  logic [pru_pkg::PIX_W-1:0]    ram_rdata,
    output logic                         in_ready,
    output logic                         res_valid,
    input  logic                         res_ready,
    output logic                         accepted,
    output logic                         out_valid,
    output logic                         is_padding,
    output logic [pru_pkg::COLOR_W-1:0]  out_blue,
    output logic [pru_pkg::COLOR_W-1:0]  out_green,
    output logic [pru_pkg::COLOR_W-1:0]  out_red,
    output logic                         end_of_row,
    output logic                         end_of_frame
);

    logic                        s1_valid_reg, s1_valid_next;
    pru_pkg::meta_t              s1_meta_reg;
    logic                        res_valid_reg, res_valid_next;
    pru_pkg::meta_t              res_meta_reg;
    logic [pru_pkg::PIX_W-1:0]   res_pix_reg;
    logic                        out_free;
    logic                        s1_move;

    assign out_free = !res_valid_reg || res_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (s1_move)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload: read data is stable while the stage waits (no read without an item)
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_meta_reg <= meta;
        end
        if (s1_move)
        begin
            res_meta_reg <= s1_meta_reg;
            res_pix_reg  <= s1_meta_reg.pixel ? ram_rdata : '0;
        end
    end

    assign res_valid    = res_valid_reg;
    assign accepted     = res_meta_reg.accepted;
    assign out_valid    = res_meta_reg.out_valid;
    assign is_padding   = res_meta_reg.is_padding;
    assign end_of_row   = res_meta_reg.end_of_row;
    assign end_of_frame = res_meta_reg.end_of_frame;
    assign out_blue     = res_pix_reg[pru_pkg::COLOR_W-1:0];
    assign out_green    = res_pix_reg[2*pru_pkg::COLOR_W-1:pru_pkg::COLOR_W];
    assign out_red      = res_pix_reg[3*pru_pkg::COLOR_W-1:2*pru_pkg::COLOR_W];

endmodule

>>> rtl/pixel_replication_upscaler.sv
// pixel_replication_upscaler: top level of the integer pixel replication upscaler.
// Depends on pru_pkg, pru_ram, pru_ctrl and pru_out.
//
//  channel  handshake             payload
//  -------  --------------------  ---------------------------------------------
//  cfg      cfg_valid/cfg_ready   cfg_index, cfg_data
//  in       in_valid/in_ready     command, blue, green, red
//  res      res_valid/res_ready   accepted, out_valid, is_padding, out_blue,
//                                 out_green, out_red, end_of_row, end_of_frame
//
// One item per clock while the res side keeps up; every item (push or pull)
// yields one result item, passed through the read stage and the output register.
// Reset (rst_n, async, active low) gives width, height and factor of 1 with
// all counters clear; no clearing pass, the line store is only read where
// written. cfg_ready is always high. A stalled res side holds one result in
// the output register and one in the read stage before in_ready drops.
module pixel_replication_upscaler (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pru_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pru_pkg::CFG_DATA_W-1:0] cfg_data,
    // input items
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           command,
    input  logic [pru_pkg::COLOR_W-1:0]    blue,
    input  logic [pru_pkg::COLOR_W-1:0]    green,
    input  logic [pru_pkg::COLOR_W-1:0]    red,
    // result items
    output logic                           res_valid,
    input  logic                           res_ready,
    output logic                           accepted,
    output logic                           out_valid,
    output logic                           is_padding,
    output logic [pru_pkg::COLOR_W-1:0]    out_blue,
    output logic [pru_pkg::COLOR_W-1:0]    out_green,
    output logic [pru_pkg::COLOR_W-1:0]    out_red,
    output logic                           end_of_row,
    output logic                           end_of_frame
);

    logic                        in_fire;
    logic                        ram_we;
    logic [pru_pkg::ADDR_W-1:0]  ram_waddr;
    logic [pru_pkg::PIX_W-1:0]   ram_wdata;
    logic                        ram_re;
    logic [pru_pkg::ADDR_W-1:0]  ram_raddr;
    logic [pru_pkg::PIX_W-1:0]   ram_rdata;
    pru_pkg::meta_t              meta;

    // Register writes take effect at once; the user must issue them only while idle, unchecked by the block
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;

    // Control: counters in flops, decides push/pull outcome in the accept cycle
    pru_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_fire   (in_fire),
        .command   (command),
        .pix       ({red, green, blue}),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .meta      (meta)
    );

    // Line store: a push writes at the accept edge, so a pull of that pixel
    // in the very next cycle already reads the new entry
    pru_ram #(
        .WIDTH (pru_pkg::PIX_W),
        .DEPTH (pru_pkg::MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result stage and output register
    pru_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (in_fire),
        .meta         (meta),
        .ram_rdata    (ram_rdata),
        .in_ready     (in_ready),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .accepted     (accepted),
        .out_valid    (out_valid),
        .is_padding   (is_padding),
        .out_blue     (out_blue),
        .out_green    (out_green),
        .out_red      (out_red),
        .end_of_row   (end_of_row),
        .end_of_frame (end_of_frame)
    );

endmodule
